// File: rtl/core/assert_macros.svh
// Assertion helpers included by serial_register_access_slave_unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define SRAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SRAS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/sras_pkg.sv
// ----------------------------------------------------------------------------
// sras_pkg
// Shared types and constants of the serial register access slave.
// ----------------------------------------------------------------------------
package sras_pkg;

  localparam int unsigned NUM_REGS_DEF = 6;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned WORD_W       = 32;

  localparam logic [7:0] CMD_READ  = 8'h12;
  localparam logic [7:0] CMD_WRITE = 8'h34;
  localparam logic [7:0] TX_IDLE   = 8'hFF;

  typedef enum logic [1:0] {
    MODE_RX  = 2'd0,
    MODE_REQ = 2'd1,
    MODE_ERR = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_INDEX = 2'd1,
    PH_WDATA = 2'd2,
    PH_RDATA = 2'd3
  } phase_e;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [WORD_W-1:0]  wdata;
  } wr_req_t;

endpackage

// File: rtl/core/sras_if.sv
// ----------------------------------------------------------------------------
// sras_in_if / sras_out_if
// Valid/ready channels carrying bus events in and responses out.
// ----------------------------------------------------------------------------
interface sras_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface sras_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       accepted;
  logic       write_done;

  modport source (output valid, tx_byte, tx_valid, accepted, write_done, input ready);
  modport sink   (input valid, tx_byte, tx_valid, accepted, write_done, output ready);
endinterface

// File: rtl/core/sras_regfile.sv
// ----------------------------------------------------------------------------
// sras_regfile
// Register file of 32-bit 16.16 words, one write and one read port.
// ----------------------------------------------------------------------------
module sras_regfile #(
  parameter int unsigned NumRegs = sras_pkg::NUM_REGS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sras_pkg::wr_req_t                 wr_req_i,
  input  logic [sras_pkg::IDX_W-1:0]        raddr_i,
  output logic [sras_pkg::WORD_W-1:0]       rdata_o
);
  import sras_pkg::*;

  logic [WORD_W-1:0] regs_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_req_i.we && (32'(wr_req_i.waddr) < NumRegs)) begin
      regs_q[wr_req_i.waddr] <= wr_req_i.wdata;
    end
  end

  // Out-of-range reads return zero; the caller never uses them.
  always_comb begin
    rdata_o = '0;
    for (int i = 0; i < NumRegs; i++) begin
      if (32'(raddr_i) == i) begin
        rdata_o = regs_q[i];
      end
    end
  end

endmodule

// File: rtl/core/serial_register_access_slave_unit.sv
// ----------------------------------------------------------------------------
// serial_register_access_slave_unit
// Slave side of a byte-serial register read/write protocol.
// ----------------------------------------------------------------------------
// Each input transaction is one bus event (received byte, master request for
// the next byte, or bus error) and yields exactly one response transaction.
// A command byte 0x12 (read) or 0x34 (write) opens an exchange, an index byte
// below NumRegs selects a register, then four data bytes move low byte first.
// Anything unexpected restarts the exchange and reports accepted = 0. The
// block takes one event per clock while the response side keeps up: an
// event is held in the input register, and the per-event state update is a
// single pass of logic from there into the response register. The register
// file resets to all zero.
module serial_register_access_slave_unit #(
  parameter int unsigned NumRegs = sras_pkg::NUM_REGS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sras_in_if.sink    in_i,
  sras_out_if.source out_o
);
  import sras_pkg::*;

  // Input register
  logic       in_vld_q;
  logic [1:0] mode_q;
  logic [7:0] rx_q;

  // Response register
  logic       out_vld_q;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic       tx_valid_q, tx_valid_d;
  logic       accepted_q, accepted_d;
  logic       wr_done_q, wr_done_d;

  // Exchange state
  phase_e            phase_q, phase_d;
  logic              is_read_q, is_read_d;
  logic [IDX_W-1:0]  sel_q, sel_d;
  logic [1:0]        bcnt_q, bcnt_d;
  logic [WORD_W-1:0] shift_q, shift_d;

  logic              adv;
  logic              idx_ok;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wr_word;
  wr_req_t           wr_req;

  // Advance the input register into the response register when the
  // response slot is free or being drained this cycle.
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      rx_q   <= in_i.rx_byte;
    end
  end

  assign idx_ok = (rx_q < 8'(NumRegs));

  // Write word with the current byte lane replaced by the received byte.
  always_comb begin
    wr_word = shift_q;
    unique case (bcnt_q)
      2'd0:    wr_word[7:0]   = rx_q;
      2'd1:    wr_word[15:8]  = rx_q;
      2'd2:    wr_word[23:16] = rx_q;
      default: wr_word[31:24] = rx_q;
    endcase
  end

  sras_regfile #(
    .NumRegs (NumRegs)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_req_i (wr_req),
    .raddr_i  (rx_q[IDX_W-1:0]),
    .rdata_o  (rdata)
  );

  // Next-state logic of the exchange.
  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    sel_d     = sel_q;
    bcnt_d    = bcnt_q;
    shift_d   = shift_q;
    unique case (mode_e'(mode_q))
      MODE_RX: begin
        unique case (phase_q)
          PH_CMD: begin
            if (rx_q == CMD_READ || rx_q == CMD_WRITE) begin
              is_read_d = (rx_q == CMD_READ);
              phase_d   = PH_INDEX;
            end else begin
              bcnt_d = 2'd0;
            end
          end
          PH_INDEX: begin
            bcnt_d = 2'd0;
            if (idx_ok) begin
              sel_d = rx_q[IDX_W-1:0];
              if (is_read_q) begin
                shift_d = rdata;
                phase_d = PH_RDATA;
              end else begin
                shift_d = '0;
                phase_d = PH_WDATA;
              end
            end else begin
              phase_d = PH_CMD;
            end
          end
          PH_WDATA: begin
            shift_d = wr_word;
            if (bcnt_q == 2'd3) begin
              phase_d = PH_CMD;
              bcnt_d  = 2'd0;
            end else begin
              bcnt_d = bcnt_q + 2'd1;
            end
          end
          default: begin
            phase_d = PH_CMD;
            bcnt_d  = 2'd0;
          end
        endcase
      end
      MODE_REQ: begin
        if (phase_q == PH_RDATA && bcnt_q != 2'd3) begin
          bcnt_d = bcnt_q + 2'd1;
        end else begin
          phase_d = PH_CMD;
          bcnt_d  = 2'd0;
        end
      end
      default: begin
        // Bus error and the unused mode code drop the exchange.
        phase_d = PH_CMD;
        bcnt_d  = 2'd0;
      end
    endcase
  end

  // Response fields and register write request.
  always_comb begin
    tx_byte_d    = TX_IDLE;
    tx_valid_d   = 1'b0;
    accepted_d   = 1'b0;
    wr_done_d    = 1'b0;
    wr_req.we    = 1'b0;
    wr_req.waddr = sel_q;
    wr_req.wdata = wr_word;
    unique case (mode_e'(mode_q))
      MODE_RX: begin
        unique case (phase_q)
          PH_CMD:   accepted_d = (rx_q == CMD_READ || rx_q == CMD_WRITE);
          PH_INDEX: accepted_d = idx_ok;
          PH_WDATA: begin
            accepted_d = 1'b1;
            if (bcnt_q == 2'd3) begin
              wr_done_d = 1'b1;
              wr_req.we = adv;
            end
          end
          default: accepted_d = 1'b0;
        endcase
      end
      MODE_REQ: begin
        if (phase_q == PH_RDATA) begin
          tx_byte_d  = shift_q[8*bcnt_q +: 8];
          tx_valid_d = 1'b1;
          accepted_d = 1'b1;
        end
      end
      default: accepted_d = 1'b0;
    endcase
  end

  // Commit state and the response only when the event advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CMD;
      is_read_q <= 1'b0;
      sel_q     <= '0;
      bcnt_q    <= 2'd0;
      shift_q   <= '0;
    end else if (adv) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      sel_q     <= sel_d;
      bcnt_q    <= bcnt_d;
      shift_q   <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_byte_q  <= tx_byte_d;
      tx_valid_q <= tx_valid_d;
      accepted_q <= accepted_d;
      wr_done_q  <= wr_done_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.tx_byte    = tx_byte_q;
  assign out_o.tx_valid   = tx_valid_q;
  assign out_o.accepted   = accepted_q;
  assign out_o.write_done = wr_done_q;

  `include "assert_macros.svh"

  `SRAS_ASSERT(a_wr_done_restarts, adv && wr_done_d |=> phase_q == PH_CMD, "write did not restart")
  `SRAS_ASSERT(a_idle_byte, out_vld_q && !tx_valid_q |-> tx_byte_q == TX_IDLE, "idle tx byte not 0xFF")
  `SRAS_NEVER(a_count_in_header, (phase_q == PH_CMD || phase_q == PH_INDEX) && bcnt_q != 2'd0, "byte count not clear before data")
  `SRAS_ASSERT(a_write_needs_phase, wr_req.we |-> phase_q == PH_WDATA && bcnt_q == 2'd3, "register write outside last data byte")

endmodule
